>>> src/drq_pkg.sv
// Shared types and codes for the duplicate-suppressing ring queue.
package drq_pkg;

  // Request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_PUSHED = 3'd0,
    ST_DUP    = 3'd1,
    ST_POPPED = 3'd2,
    ST_FULL   = 3'd3,
    ST_EMPTY  = 3'd4
  } drq_status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_PUT  = 3'b100
  } drq_state_t;

  // Command to the search unit
  typedef struct packed {
    logic        start;
    logic        pop;
    logic [15:0] key;
  } drq_cmd_t;

  // Answer from the search unit
  typedef struct packed {
    logic        done;
    logic        found;
    logic [15:0] data;
  } drq_res_t;

endpackage

>>> src/drq_search.sv
// Slot memory with one read port and the shared comparator that walks it.
module drq_search #(
  parameter int SLOTS = 32
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  drq_pkg::drq_cmd_t                        cmd,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] head,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] tail,
  input  logic                                     wr_en,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] wr_addr,
  input  logic [15:0]                              wr_data,
  output drq_pkg::drq_res_t                        res
);
  import drq_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  logic [15:0]   mem [SLOTS];
  logic [15:0]   rd_data;
  logic          rd_en;
  logic [IW-1:0] rd_addr;

  logic          busy;
  logic          is_pop;
  logic          pend;
  logic [IW-1:0] cur;
  logic [15:0]   key;
  logic          hit;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Single comparator against the last slot read
  assign hit = pend && (rd_data == key);

  // Read address: head on a pop start, walking pointer during a push scan
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur;
    res     = '0;
    if (cmd.start && cmd.pop) begin
      rd_en   = 1'b1;
      rd_addr = head;
    end else if (busy && is_pop) begin
      res.done = 1'b1;
      res.data = rd_data;
    end else if (busy) begin
      if (hit) begin
        res.done  = 1'b1;
        res.found = 1'b1;
      end else if (cur == tail) begin
        res.done = 1'b1;
      end else begin
        rd_en = 1'b1;
      end
    end
  end

  // Scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      pend   <= 1'b0;
      is_pop <= 1'b0;
    end else if (cmd.start) begin
      busy   <= 1'b1;
      is_pop <= cmd.pop;
      pend   <= cmd.pop;
    end else if (busy) begin
      if (res.done) begin
        busy <= 1'b0;
        pend <= 1'b0;
      end else begin
        pend <= 1'b1;
      end
    end
  end

  // Walking pointer and search key
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur <= head;
      key <= cmd.key;
    end else if (rd_en) begin
      cur <= next_slot(cur);
    end
  end

endmodule

>>> src/dedup_ring_queue_unit.sv
// Top level of the duplicate-suppressing ring queue of block numbers.
//
// A ring of SLOTS block numbers that holds at most SLOTS-1 entries. A push
// (req_type 0) compares block_id against every occupied slot from head to
// tail through one memory read port and one comparator, one slot per cycle;
// a match returns status 1 and changes nothing, a full queue returns status 3,
// otherwise the entry is appended with status 0. A pop (req_type 1) returns the
// head entry with status 2, or status 4 and block 0 when empty. Each result
// carries now_empty. The block takes one item at a time: it accepts a new
// request only after the result of the last one is loaded. The memory needs
// no clearing pass.
module dedup_ring_queue_unit #(
  parameter int SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [15:0] block_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] block_out,
  output logic [2:0]  status,
  output logic        now_empty
);
  import drq_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  drq_state_t    state;
  logic [IW-1:0] head;
  logic [IW-1:0] tail;
  logic          req_pop;
  logic [15:0]   blk_r;
  drq_status_t   st_r;
  // Key held for the write
  logic [15:0]   key_r;

  drq_cmd_t      cmd;
  drq_res_t      res;
  logic          in_fire;
  logic          empty;
  logic          full;
  logic          wr_en;
  logic          out_free;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  // Handshake and queue condition
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign empty    = (head == tail);
  assign full     = (next_slot(tail) == head);
  assign out_free = !out_valid || out_ready;

  // Search unit command; an empty pop needs no memory access
  always_comb begin
    cmd.start = in_fire && !(req_type == REQ_POP && empty);
    cmd.pop   = (req_type == REQ_POP);
    cmd.key   = block_id;
  end

  // Append on a push that found no match and has room
  assign wr_en = (state == S_SRCH) && res.done && (req_pop == REQ_PUSH)
                 && !res.found && !full;

  drq_search #(
    .SLOTS(SLOTS)
  ) u_search (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .head    (head),
    .tail    (tail),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (key_r),
    .res     (res)
  );

  // Sequencer, pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      out_valid <= 1'b0;
    end else begin
      // the result state reloads the register itself
      if (out_valid && out_ready && state != S_PUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            req_pop <= req_type;
            key_r   <= block_id;
            if (req_type == REQ_POP && empty) begin
              st_r  <= ST_EMPTY;
              blk_r <= '0;
              state <= S_PUT;
            end else begin
              state <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          if (res.done) begin
            state <= S_PUT;
            if (req_pop == REQ_POP) begin
              blk_r <= res.data;
              st_r  <= ST_POPPED;
              head  <= next_slot(head);
            end else begin
              blk_r <= '0;
              if (res.found) begin
                st_r <= ST_DUP;
              end else if (full) begin
                st_r <= ST_FULL;
              end else begin
                st_r <= ST_PUSHED;
                tail <= next_slot(tail);
              end
            end
          end
        end
        S_PUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            block_out <= blk_r;
            status    <= st_r;
            now_empty <= empty;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Search answers only arrive while the sequencer waits for them
  a_done_in_srch: assert property (@(posedge clk) disable iff (rst)
    res.done |-> (state == S_SRCH))
    else $error("search answer outside search state");

  // A new result is loaded only from the result state
  a_load_from_put: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_PUT))
    else $error("result loaded outside result state");

  // Head and tail never move on the same edge
  a_one_ptr_moves: assert property (@(posedge clk) disable iff (rst)
    (head != $past(head)) |-> (tail == $past(tail)))
    else $error("head and tail moved together");

  // The queue never fills its last free slot
  a_one_free: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (next_slot(tail) != head))
    else $error("append into the reserved slot");

endmodule
